// ===== sv/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg: shared types and codes of the sorted timer queue
// Action and result codes, sequencer states and the queue cell entry format.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int SLOT_W = 5;
  localparam int CH_W   = 4;
  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;
  localparam int KIND_W = 3;

  localparam logic [SLOT_W-1:0] MAX_EXPIRIES = 5'd31;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC  = 3'd0,
    ACT_FREE   = 3'd1,
    ACT_BIND   = 3'd2,
    ACT_ARM    = 3'd3,
    ACT_CANCEL = 3'd4,
    ACT_TICK   = 3'd5
  } act_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC     = 3'd0,
    KIND_ACK       = 3'd1,
    KIND_CANCEL    = 3'd2,
    KIND_EXPIRY    = 3'd3,
    KIND_TICK_DONE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INSERT,
    ST_POP
  } st_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_POP
  } cell_op_e;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] id;
    logic [DATA_W-1:0] dl;
  } entry_t;

  typedef struct packed {
    cell_op_e          op;
    logic [SLOT_W-1:0] id;
    logic [DATA_W-1:0] dl;
  } cell_ctrl_t;

endpackage

// ===== sv/stq_cell.sv =====
// ----------------------------------------------------------------------------
// stq_cell: one place of the sorted deadline queue
// Holds one running slot and its deadline; shifts right on an insert ahead of
// it and left on a removal at or before it, or on a head pop.
// ----------------------------------------------------------------------------
module stq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stq_pkg::cell_ctrl_t ctrl_i,
  input  stq_pkg::entry_t    left_i,
  input  stq_pkg::entry_t    right_i,
  input  logic               ins_left_i,
  input  logic               rm_left_i,
  output stq_pkg::entry_t    entry_o,
  output logic               ins_o,
  output logic               rm_o
);

  stq_pkg::entry_t entry_q, entry_d;

  assign ins_o = !entry_q.valid || (entry_q.dl >= ctrl_i.dl);
  assign rm_o  = rm_left_i || (entry_q.valid && (entry_q.id == ctrl_i.id));

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      stq_pkg::OP_INSERT: begin
        if (ins_o) begin
          if (ins_left_i) begin
            entry_d = left_i;
          end else begin
            entry_d.valid = 1'b1;
            entry_d.id    = ctrl_i.id;
            entry_d.dl    = ctrl_i.dl;
          end
        end
      end
      stq_pkg::OP_REMOVE: begin
        if (rm_o) begin
          entry_d = right_i;
        end
      end
      stq_pkg::OP_POP: begin
        entry_d = right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

`ifndef NO_ASSERTIONS
  // queue stays packed towards the head
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    right_i.valid |-> entry_q.valid)
    else $error("queue has a gap");

  // queue stays ordered by deadline
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_q.valid && right_i.valid) |-> (entry_q.dl <= right_i.dl))
    else $error("queue out of deadline order");
`endif

endmodule

// ===== sv/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue: timer slot pool with a deadline-sorted run queue
// Allocates, frees, binds, arms and cancels timer slots and pops expired
// slots on each tick from a chain of queue cells kept in deadline order.
// ----------------------------------------------------------------------------
//  channel   ports                                     transfer
//  command   start, busy, action_i .. delay_i          start high, busy low
//  result    strobe_o, kind_o .. last_o                strobe_o high, 1 cycle
//  config    cfg_valid_i, cfg_ready_o, cfg_task_slot_i valid and ready high
//
//  allocate, free, bind, cancel: the execution step, then back to idle
//  arm: removal pass then insertion pass through the cell chain,
//  the execution step alone when refused
//  tick: the execution step, then head pops, one head pop per cycle
//  result is registered, shown in the cycle after the step that makes it; no clearing pass
//  reset returns all slots but slot 0 free, queue empty, tick count zero
//  results cannot be held off; a new command may start while one is shown
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
  parameter int TIMER_SLOTS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [stq_pkg::ACT_W-1:0]       action_i,
  input  logic [stq_pkg::SLOT_W-1:0]      slot_i,
  input  logic [stq_pkg::CH_W-1:0]        channel_id_i,
  input  logic signed [stq_pkg::DATA_W-1:0] payload_i,
  input  logic [stq_pkg::DATA_W-1:0]      delay_i,
  output logic                            strobe_o,
  output logic [stq_pkg::KIND_W-1:0]      kind_o,
  output logic [stq_pkg::SLOT_W-1:0]      result_slot_o,
  output logic                            ok_o,
  output logic [stq_pkg::CH_W-1:0]        out_channel_o,
  output logic signed [stq_pkg::DATA_W-1:0] out_payload_o,
  output logic                            ctx_switch_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [stq_pkg::SLOT_W-1:0]      cfg_task_slot_i
);

  localparam int ARM_SLOTS = (TIMER_SLOTS < 32) ? TIMER_SLOTS : 32;
  localparam int NCELL     = ARM_SLOTS - 1;
  localparam int RW        = $clog2(ARM_SLOTS);
  localparam int GROUPS    = (TIMER_SLOTS + 7) / 8;
  localparam int FW        = GROUPS * 8;
  localparam int AW        = $clog2(FW);

  stq_pkg::st_e   state_q, state_d;
  stq_pkg::act_e  act_q;
  logic [stq_pkg::SLOT_W-1:0] slot_q;
  logic [stq_pkg::CH_W-1:0]   ch_q;
  logic [stq_pkg::DATA_W-1:0] pay_q;
  logic [stq_pkg::DATA_W-1:0] delay_q;
  logic [stq_pkg::DATA_W-1:0] dl_q, dl_d;
  logic [stq_pkg::DATA_W-1:0] tick_q, tick_d;
  logic [stq_pkg::SLOT_W-1:0] task_q;
  logic [FW-1:0]              free_q, free_d;
  logic [ARM_SLOTS-1:0]       run_q, run_d;
  logic [stq_pkg::SLOT_W-1:0] n_q, n_d;
  logic                       sw_q, sw_d;

  logic [GROUPS-1:0] grp_found_q, grp_found_d;
  logic [2:0]        grp_idx_q [GROUPS];
  logic [2:0]        grp_idx_d [GROUPS];

  logic                       strobe_q;
  stq_pkg::kind_e             kind_q, e_kind;
  logic [stq_pkg::SLOT_W-1:0] rslot_q, e_slot;
  logic                       ok_q, e_ok;
  logic                       ts_q, e_ts;
  logic                       last_q, e_last;
  logic                       emit;

  logic [stq_pkg::CH_W-1:0]   mem_ch_q  [ARM_SLOTS];
  logic [stq_pkg::DATA_W-1:0] mem_pay_q [ARM_SLOTS];
  logic [stq_pkg::CH_W-1:0]   ch_rd_q;
  logic [stq_pkg::DATA_W-1:0] pay_rd_q;
  logic                       wr_en, rd_en;

  stq_pkg::cell_ctrl_t ctrl;
  stq_pkg::entry_t     cell_q [NCELL];
  logic [NCELL-1:0]    ins_w, rm_w, cell_valid;
  stq_pkg::entry_t     head;

  logic          valid_s;
  logic [RW-1:0] sidx;
  logic [AW-1:0] fidx;
  logic [AW-1:0] alloc_idx;
  logic          alloc_found;
  logic          is_task, due, pop;

  assign busy        = (state_q != stq_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign valid_s = (slot_q != '0) && (int'(slot_q) < TIMER_SLOTS);
  assign sidx    = RW'(slot_q);
  assign fidx    = AW'(slot_q);

  assign head    = cell_q[0];
  assign is_task = (task_q != '0) && (head.id == task_q);
  assign due     = head.valid && (head.dl <= tick_q);
  assign pop     = due && (is_task || (n_q != stq_pkg::MAX_EXPIRIES));

  // queue cell chain
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    stq_pkg::entry_t left_w, right_w;
    logic            ins_l, rm_l;
    if (i == 0) begin : g_first
      assign left_w = '0;
      assign ins_l  = 1'b0;
      assign rm_l   = 1'b0;
    end else begin : g_inner
      assign left_w = cell_q[i-1];
      assign ins_l  = ins_w[i-1];
      assign rm_l   = rm_w[i-1];
    end
    if (i == NCELL - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid
      assign right_w = cell_q[i+1];
    end
    stq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .left_i     (left_w),
      .right_i    (right_w),
      .ins_left_i (ins_l),
      .rm_left_i  (rm_l),
      .entry_o    (cell_q[i]),
      .ins_o      (ins_w[i]),
      .rm_o       (rm_w[i])
    );
    assign cell_valid[i] = cell_q[i].valid;
  end

  // first free slot of each group of eight
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_found_d[g] = 1'b0;
      grp_idx_d[g]   = '0;
      for (int b = 7; b >= 0; b--) begin
        if (free_q[g*8+b]) begin
          grp_found_d[g] = 1'b1;
          grp_idx_d[g]   = 3'(b);
        end
      end
    end
  end

  always_comb begin
    alloc_found = 1'b0;
    alloc_idx   = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_found_q[g]) begin
        alloc_found = 1'b1;
        alloc_idx   = AW'(g * 8) | AW'(grp_idx_q[g]);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stq_pkg::ST_IDLE: begin
        if (start) begin
          state_d = stq_pkg::ST_EXEC;
        end
      end
      stq_pkg::ST_EXEC: begin
        if (act_q == stq_pkg::ACT_ARM && valid_s && !free_q[fidx]) begin
          state_d = stq_pkg::ST_INSERT;
        end else if (act_q == stq_pkg::ACT_TICK) begin
          state_d = stq_pkg::ST_POP;
        end else begin
          state_d = stq_pkg::ST_IDLE;
        end
      end
      stq_pkg::ST_INSERT: begin
        state_d = stq_pkg::ST_IDLE;
      end
      stq_pkg::ST_POP: begin
        if (!pop) begin
          state_d = stq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stq_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and results
  always_comb begin
    free_d  = free_q;
    run_d   = run_q;
    tick_d  = tick_q;
    dl_d    = dl_q;
    n_d     = n_q;
    sw_d    = sw_q;
    ctrl.op = stq_pkg::OP_HOLD;
    ctrl.id = slot_q;
    ctrl.dl = dl_q;
    emit    = 1'b0;
    e_kind  = stq_pkg::KIND_ACK;
    e_slot  = slot_q;
    e_ok    = 1'b0;
    e_ts    = 1'b0;
    e_last  = 1'b1;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    unique case (state_q)
      stq_pkg::ST_EXEC: begin
        unique case (act_q)
          stq_pkg::ACT_ALLOC: begin
            emit   = 1'b1;
            e_kind = stq_pkg::KIND_ALLOC;
            e_slot = '0;
            if (alloc_found) begin
              free_d[alloc_idx] = 1'b0;
              e_slot            = stq_pkg::SLOT_W'(alloc_idx);
              e_ok              = 1'b1;
            end
          end
          stq_pkg::ACT_FREE: begin
            emit = 1'b1;
            e_ok = valid_s;
            if (valid_s) begin
              ctrl.op      = stq_pkg::OP_REMOVE;
              run_d[sidx]  = 1'b0;
              free_d[fidx] = 1'b1;
            end
          end
          stq_pkg::ACT_BIND: begin
            emit  = 1'b1;
            e_ok  = valid_s;
            wr_en = valid_s;
          end
          stq_pkg::ACT_ARM: begin
            if (!valid_s || free_q[fidx]) begin
              emit = 1'b1;
            end else begin
              ctrl.op     = stq_pkg::OP_REMOVE;
              run_d[sidx] = 1'b1;
              dl_d        = tick_q + delay_q;
            end
          end
          stq_pkg::ACT_CANCEL: begin
            emit   = 1'b1;
            e_kind = stq_pkg::KIND_CANCEL;
            if (valid_s && run_q[sidx]) begin
              ctrl.op     = stq_pkg::OP_REMOVE;
              run_d[sidx] = 1'b0;
              e_ok        = 1'b1;
            end
          end
          stq_pkg::ACT_TICK: begin
            tick_d = tick_q + 1'b1;
            n_d    = '0;
            sw_d   = 1'b0;
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      stq_pkg::ST_INSERT: begin
        ctrl.op = stq_pkg::OP_INSERT;
        emit    = 1'b1;
        e_ok    = 1'b1;
      end
      stq_pkg::ST_POP: begin
        if (pop) begin
          ctrl.op            = stq_pkg::OP_POP;
          run_d[RW'(head.id)] = 1'b0;
          if (is_task) begin
            sw_d = 1'b1;
          end else begin
            emit   = 1'b1;
            e_kind = stq_pkg::KIND_EXPIRY;
            e_slot = head.id;
            e_last = 1'b0;
            rd_en  = 1'b1;
            n_d    = n_q + 1'b1;
          end
        end else begin
          emit   = 1'b1;
          e_kind = stq_pkg::KIND_TICK_DONE;
          e_slot = '0;
          e_ts   = sw_q;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stq_pkg::ST_IDLE;
      tick_q      <= '0;
      task_q      <= '0;
      free_q      <= FW'({{(TIMER_SLOTS-1){1'b1}}, 1'b0});
      run_q       <= '0;
      n_q         <= '0;
      sw_q        <= 1'b0;
      strobe_q    <= 1'b0;
      grp_found_q <= '0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      free_q      <= free_d;
      run_q       <= run_d;
      n_q         <= n_d;
      sw_q        <= sw_d;
      strobe_q    <= emit;
      grp_found_q <= grp_found_d;
      if (cfg_valid_i) begin
        task_q <= cfg_task_slot_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_idx_q <= grp_idx_d;
    dl_q      <= dl_d;
    kind_q    <= e_kind;
    rslot_q   <= e_slot;
    ok_q      <= e_ok;
    ts_q      <= e_ts;
    last_q    <= e_last;
    if (state_q == stq_pkg::ST_IDLE && start) begin
      act_q   <= stq_pkg::act_e'(action_i);
      slot_q  <= slot_i;
      ch_q    <= channel_id_i;
      pay_q   <= payload_i;
      delay_q <= delay_i;
    end
  end

  // channel and data store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_ch_q[sidx]  <= ch_q;
      mem_pay_q[sidx] <= pay_q;
    end
    if (rd_en) begin
      ch_rd_q  <= mem_ch_q[RW'(head.id)];
      pay_rd_q <= mem_pay_q[RW'(head.id)];
    end
  end

  assign strobe_o      = strobe_q;
  assign kind_o        = kind_q;
  assign result_slot_o = rslot_q;
  assign ok_o          = ok_q;
  assign ctx_switch_o  = ts_q;
  assign last_o        = last_q;
  assign out_channel_o = (kind_q == stq_pkg::KIND_EXPIRY) ? ch_rd_q : '0;
  assign out_payload_o = (kind_q == stq_pkg::KIND_EXPIRY) ? pay_rd_q : '0;

`ifndef NO_ASSERTIONS
  // every result comes out of a command in progress
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("result without a command");

  // the final result of a command coincides with the return to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (last_o == !busy))
    else $error("last flag out of step with sequencer");

  // queue occupancy matches the running slot count outside an insertion
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != stq_pkg::ST_INSERT) |-> ($countones(cell_valid) == $countones(run_q)))
    else $error("queue occupancy differs from running slots");

  // a queued head slot is marked running
  a_head_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head.valid |-> run_q[RW'(head.id)])
    else $error("queued slot not marked running");
`endif

endmodule
